>>> sv/qtot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qtot_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int VTX_WIDTH = 32;
	localparam int NUM_QUAD_VTX = 4;
	localparam int NUM_TRI_VTX = 3;

	// directed quad edges: first half q0q1 q1q2 q2q0, second half q0q2 q2q3 q3q0
	localparam int NUM_QUAD_EDGE = 6;
	localparam int QE_A [NUM_QUAD_EDGE] = '{0, 1, 2, 0, 2, 3};
	localparam int QE_B [NUM_QUAD_EDGE] = '{1, 2, 0, 2, 3, 0};

	// quad edge against triangle vertex, triangle edge against quad vertex
	localparam int NUM_QO = NUM_QUAD_EDGE * NUM_TRI_VTX;
	localparam int NUM_TO = NUM_TRI_VTX * NUM_QUAD_VTX;

	typedef struct packed {
		logic pos;
		logic neg;
	} sgn_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage
`default_nettype wire

>>> sv/qtot_orient_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module qtot_orient_unit #(
	parameter int COORD_WIDTH = qtot_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire qtot_pkg::stage_en_t           en,
	input  wire logic signed [COORD_WIDTH-1:0] ax,
	input  wire logic signed [COORD_WIDTH-1:0] ay,
	input  wire logic signed [COORD_WIDTH-1:0] bx,
	input  wire logic signed [COORD_WIDTH-1:0] by,
	input  wire logic signed [COORD_WIDTH-1:0] cx,
	input  wire logic signed [COORD_WIDTH-1:0] cy,
	output qtot_pkg::sgn_t                     sgn
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e;
	logic signed [DW-1:0] dbx_s1, dby_s1, dcx_s1, dcy_s1;
	logic signed [PW-1:0] lhs_s2, rhs_s2;
	qtot_pkg::sgn_t       sgn_s3;

	assign ax_e = {ax[COORD_WIDTH-1], ax};
	assign ay_e = {ay[COORD_WIDTH-1], ay};
	assign bx_e = {bx[COORD_WIDTH-1], bx};
	assign by_e = {by[COORD_WIDTH-1], by};
	assign cx_e = {cx[COORD_WIDTH-1], cx};
	assign cy_e = {cy[COORD_WIDTH-1], cy};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			dbx_s1 <= bx_e - ax_e;
			dby_s1 <= by_e - ay_e;
			dcx_s1 <= cx_e - ax_e;
			dcy_s1 <= cy_e - ay_e;
		end
		if (en.s2) begin
			lhs_s2 <= PW'(dbx_s1) * PW'(dcy_s1);
			rhs_s2 <= PW'(dby_s1) * PW'(dcx_s1);
		end
		if (en.s3) begin
			sgn_s3.pos <= lhs_s2 > rhs_s2;
			sgn_s3.neg <= lhs_s2 < rhs_s2;
		end
	end

	assign sgn = sgn_s3;

endmodule
`default_nettype wire

>>> sv/qtot_overlap_eval.sv
`timescale 1ns / 1ps
`default_nettype none
module qtot_overlap_eval (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire qtot_pkg::sgn_t qo [qtot_pkg::NUM_QO],
	input  wire qtot_pkg::sgn_t to [qtot_pkg::NUM_TO],
	output logic                overlap
);

	logic hit;
	logic in_pos, in_neg;
	logic overlap_s4;

	// the two sign factors of a segment test have a product at most zero
	function automatic logic not_same_side(qtot_pkg::sgn_t x, qtot_pkg::sgn_t y);
		return !((x.pos && y.pos) || (x.neg && y.neg));
	endfunction

	always_comb begin
		hit = 1'b0;

		// q0 in the triangle, shared by both halves
		in_pos = to[0].pos | to[4].pos | to[8].pos;
		in_neg = to[0].neg | to[4].neg | to[8].neg;
		if (!(in_pos && in_neg)) begin
			hit = 1'b1;
		end

		for (int h = 0; h < 2; h++) begin
			// t0 in this half of the quad
			in_pos = qo[(h*3)*3].pos | qo[(h*3+1)*3].pos | qo[(h*3+2)*3].pos;
			in_neg = qo[(h*3)*3].neg | qo[(h*3+1)*3].neg | qo[(h*3+2)*3].neg;
			if (!(in_pos && in_neg)) begin
				hit = 1'b1;
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (not_same_side(qo[(h*3+i)*3+j],
							qo[(h*3+i)*3+((j == 2) ? 0 : j + 1)]) &&
						not_same_side(to[j*4+qtot_pkg::QE_A[h*3+i]],
							to[j*4+qtot_pkg::QE_B[h*3+i]])) begin
						hit = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			overlap_s4 <= hit;
		end
	end

	assign overlap = overlap_s4;

endmodule
`default_nettype wire

>>> sv/quad_triangle_overlap_test_core.sv
// pipeline: four register stages from an accepted request to its result (differences,
// products, compare, overlap decision)
// throughput: one request per cycle; a stage holds while the one after it is full and stalled
// reset: asynchronous, clears the valid bits of all four stages; data registers keep contents
`timescale 1ns / 1ps
`default_nettype none
module quad_triangle_overlap_test_core #(
	parameter int COORD_WIDTH = qtot_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [qtot_pkg::VTX_WIDTH-1:0] quad_v0,
	input  wire logic [qtot_pkg::VTX_WIDTH-1:0] quad_v1,
	input  wire logic [qtot_pkg::VTX_WIDTH-1:0] quad_v2,
	input  wire logic [qtot_pkg::VTX_WIDTH-1:0] quad_v3,
	input  wire logic [qtot_pkg::VTX_WIDTH-1:0] tri_v0,
	input  wire logic [qtot_pkg::VTX_WIDTH-1:0] tri_v1,
	input  wire logic [qtot_pkg::VTX_WIDTH-1:0] tri_v2,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                overlap
);

	localparam int EW = (2 * COORD_WIDTH > qtot_pkg::VTX_WIDTH) ?
		2 * COORD_WIDTH : qtot_pkg::VTX_WIDTH;

	logic [qtot_pkg::VTX_WIDTH-1:0] qraw [qtot_pkg::NUM_QUAD_VTX];
	logic [qtot_pkg::VTX_WIDTH-1:0] traw [qtot_pkg::NUM_TRI_VTX];
	logic signed [COORD_WIDTH-1:0]  qx [qtot_pkg::NUM_QUAD_VTX];
	logic signed [COORD_WIDTH-1:0]  qy [qtot_pkg::NUM_QUAD_VTX];
	logic signed [COORD_WIDTH-1:0]  tx [qtot_pkg::NUM_TRI_VTX];
	logic signed [COORD_WIDTH-1:0]  ty [qtot_pkg::NUM_TRI_VTX];

	qtot_pkg::sgn_t      qo [qtot_pkg::NUM_QO];
	qtot_pkg::sgn_t      to [qtot_pkg::NUM_TO];
	qtot_pkg::stage_en_t en;
	logic                en_s4;
	logic                valid_s1, valid_s2, valid_s3, valid_s4;

	assign qraw[0] = quad_v0;
	assign qraw[1] = quad_v1;
	assign qraw[2] = quad_v2;
	assign qraw[3] = quad_v3;
	assign traw[0] = tri_v0;
	assign traw[1] = tri_v1;
	assign traw[2] = tri_v2;

	// x sits above y; bits past the field read as zero
	for (genvar k = 0; k < qtot_pkg::NUM_QUAD_VTX; k++) begin : g_qunpack
		logic [EW-1:0] ext;
		assign ext   = EW'(qraw[k]);
		assign qx[k] = ext[2*COORD_WIDTH-1:COORD_WIDTH];
		assign qy[k] = ext[COORD_WIDTH-1:0];
	end

	for (genvar k = 0; k < qtot_pkg::NUM_TRI_VTX; k++) begin : g_tunpack
		logic [EW-1:0] ext;
		assign ext   = EW'(traw[k]);
		assign tx[k] = ext[2*COORD_WIDTH-1:COORD_WIDTH];
		assign ty[k] = ext[COORD_WIDTH-1:0];
	end

	// a stage loads when it is empty or its contents move on
	assign en_s4    = !valid_s4 || !out_stall;
	assign en.s3    = !valid_s3 || en_s4;
	assign en.s2    = !valid_s2 || en.s3;
	assign en.s1    = !valid_s1 || en.s2;
	assign in_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	for (genvar e = 0; e < qtot_pkg::NUM_QUAD_EDGE; e++) begin : g_qedge
		for (genvar v = 0; v < qtot_pkg::NUM_TRI_VTX; v++) begin : g_tvtx
			qtot_orient_unit #(
				.COORD_WIDTH(COORD_WIDTH)
			) u_orient (
				.clk (clk),
				.en  (en),
				.ax  (qx[qtot_pkg::QE_A[e]]),
				.ay  (qy[qtot_pkg::QE_A[e]]),
				.bx  (qx[qtot_pkg::QE_B[e]]),
				.by  (qy[qtot_pkg::QE_B[e]]),
				.cx  (tx[v]),
				.cy  (ty[v]),
				.sgn (qo[e*qtot_pkg::NUM_TRI_VTX+v])
			);
		end
	end

	for (genvar j = 0; j < qtot_pkg::NUM_TRI_VTX; j++) begin : g_tedge
		localparam int JN = (j + 1) % qtot_pkg::NUM_TRI_VTX;
		for (genvar k = 0; k < qtot_pkg::NUM_QUAD_VTX; k++) begin : g_qvtx
			qtot_orient_unit #(
				.COORD_WIDTH(COORD_WIDTH)
			) u_orient (
				.clk (clk),
				.en  (en),
				.ax  (tx[j]),
				.ay  (ty[j]),
				.bx  (tx[JN]),
				.by  (ty[JN]),
				.cx  (qx[k]),
				.cy  (qy[k]),
				.sgn (to[j*qtot_pkg::NUM_QUAD_VTX+k])
			);
		end
	end

	qtot_overlap_eval u_eval (
		.clk     (clk),
		.en      (en_s4),
		.qo      (qo),
		.to      (to),
		.overlap (overlap)
	);

	assign out_valid = valid_s4;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && out_stall))
		else $error("input stalled while the pipeline has room");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted request did not reach stage one");

	a_held_stage_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en_s4) |=> valid_s3)
		else $error("stage three dropped a held request");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en_s4) |=> out_valid)
		else $error("stage three request did not reach the output");

endmodule
`default_nettype wire
